### rtl/ri1d_pkg.sv
// Shared types, codes and constants for the 1-D resampling interpolator.
`timescale 1ns / 1ps
`default_nettype none
package ri1d_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IN_COUNT_W  = 11;
    localparam int OUT_COUNT_W = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int NUM_W       = OUT_COUNT_W + IN_COUNT_W;

    localparam logic [IN_COUNT_W-1:0]  IN_COUNT_RST  = IN_COUNT_W'(5);
    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_RST = OUT_COUNT_W'(41);

    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ZERO    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FULL  = 2'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [1:0] REG_IN_COUNT  = 2'd0;
    localparam logic [1:0] REG_OUT_COUNT = 2'd1;
    localparam logic [1:0] REG_MODE      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV,
        ST_PREP,
        ST_WMUL,
        ST_TRD,
        ST_TMUL,
        ST_TACC,
        ST_FIN,
        ST_RDA,
        ST_RDB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [OUT_COUNT_W-1:0]        out_index;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [STATUS_W-1:0]           status;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

### rtl/ri1d_store.sv
// Sample memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ri1d_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [AW-1:0]                          i_wr_addr,
    input  wire logic signed [ri1d_pkg::SAMPLE_BITS-1:0] i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [AW-1:0]                          i_rd_addr,
    output logic signed [ri1d_pkg::SAMPLE_BITS-1:0]      o_rd_data
);
    import ri1d_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/ri1d_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ri1d_div #(
    parameter int DW = 43
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [DW-1:0]                        i_dividend,
    input  wire logic [ri1d_pkg::OUT_COUNT_W-1:0]     i_divisor,
    output logic [DW-1:0]                             o_quotient,
    output ri1d_pkg::t_div_stat                       o_stat
);
    import ri1d_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]          r_q;
    logic [OUT_COUNT_W-1:0] r_rem;
    logic [OUT_COUNT_W-1:0] r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_done;
    logic [OUT_COUNT_W:0]   trial;
    logic [OUT_COUNT_W:0]   diff;
    logic                   qbit;

    assign trial = {r_rem, r_q[DW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= qbit ? diff[OUT_COUNT_W-1:0] : trial[OUT_COUNT_W-1:0];
            r_q   <= {r_q[DW-2:0], qbit};
        end
    end

    assign o_quotient  = r_q;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

### rtl/resample_interpolator_1d.sv
// Top level of the 1-D resampling interpolator.
`timescale 1ns / 1ps
`default_nettype none
// A load transaction writes one sample into the store and gives no result. A
// request gives one result: errors and mode three go straight to the output
// state, the last point reads its sample first; other points first pass through
// a bit-serial divider, then nearest reads one sample, linear runs four taps of
// read, multiply and accumulate through one multiplier and one memory read port,
// cubic forms nine weight products first. A stalled output holds the block in
// its output state. The block takes one transaction at a time; a finished result
// waits in the output register while the next transaction is taken. No clearing
// pass after reset.
module resample_interpolator_1d #(
    parameter int MAX_SAMPLES   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire ri1d_pkg::t_in_item     i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output ri1d_pkg::t_out_item         o_out_data,
    input  wire logic                   i_out_stall,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ri1d_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int MA  = F + 3;
    localparam int MB  = (F + 3 > SB) ? F + 3 : SB;
    localparam int PW  = MA + MB;
    localparam int AC  = PW + 2;
    localparam int DW  = NUM_W + F;
    localparam int NW  = IN_COUNT_W;

    localparam logic signed [MA-1:0] U_S     = MA'(64'd1 << F);
    localparam logic signed [MA-1:0] RECIP3  = MA'(((64'd1 << F) + 64'd2) / 64'd3);
    localparam logic signed [PW-1:0] HALF_P  = PW'(64'd1 << (F - 1));
    localparam logic signed [PW-1:0] U_P     = PW'(64'd1 << F);
    localparam logic signed [PW-1:0] THREE_P = PW'(64'd3 << F);
    localparam logic signed [AC-1:0] HALF_A  = AC'(64'd1 << (F - 1));

    t_state r_state, n_state;

    logic [IN_COUNT_W-1:0]  r_in_count;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic [MODE_W-1:0]      r_mode;
    logic [NW-1:0]          r_wptr;
    logic                   r_full;

    logic [NUM_W-1:0]       r_num;
    logic [NW-1:0]          r_ix;
    logic [F-1:0]           r_d;
    logic signed [MA-1:0]   r_de, r_dh, r_he, r_z;
    logic signed [MA-1:0]   r_w [4];
    logic [3:0]             r_step;
    logic [1:0]             r_tap;
    logic signed [PW-1:0]   r_prod;
    logic signed [AC-1:0]   r_acc;
    logic [AW-1:0]          r_addr;
    logic signed [SB-1:0]   r_res_value;
    logic [STATUS_W-1:0]    r_res_status;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic                   cfg_wr;
    logic [16:0]            in_ext;
    logic [NW-1:0]          n_eff;
    logic [NW-1:0]          n_last;
    logic [NW-1:0]          wptr_inc;
    logic                   in_acc;
    logic                   is_load;
    logic                   is_req;
    logic                   bad_idx;
    logic                   is_last;
    logic                   out_free;

    logic                   div_start;
    logic [DW-1:0]          div_q;
    t_div_stat              div_stat;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic signed [SB-1:0]   rd_data;

    logic signed [MA-1:0]   d_s, e_s, h_s, g_s;
    logic signed [MA-1:0]   mul_a;
    logic signed [MB-1:0]   mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [PW-1:0]   p_half, p_u, p_three;

    logic [NW:0]            ix_p2;
    logic [NW-1:0]          tap_idx;
    logic signed [AC-1:0]   acc_t, acc_q;
    logic                   acc_ovf;
    logic signed [SB-1:0]   acc_sat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_IN_COUNT:  prdata = 32'(r_in_count);
            REG_OUT_COUNT: prdata = 32'(r_out_count);
            REG_MODE:      prdata = 32'(r_mode);
            default:       prdata = '0;
        endcase
    end

    // effective set size, clamped to [2, MAX_SAMPLES]
    assign in_ext   = 17'(r_in_count);
    assign n_eff    = (in_ext < 17'd2) ? NW'(2) :
                      (in_ext > 17'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : r_in_count;
    assign n_last   = n_eff - 1'b1;
    assign wptr_inc = r_wptr + 1'b1;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_load  = in_acc && (i_in_data.command == CMD_LOAD);
    assign is_req   = in_acc && (i_in_data.command == CMD_REQUEST);
    assign bad_idx  = (i_in_data.out_index >= r_out_count);
    assign is_last  = (i_in_data.out_index == r_out_count - 1'b1);
    assign out_free = !r_out_valid || !i_out_stall;

    // fraction terms
    assign d_s = MA'({3'b000, r_d});
    assign e_s = U_S - d_s;
    assign h_s = U_S + d_s;
    assign g_s = U_S + U_S - d_s;

    assign mul_p   = mul_a * mul_b;
    assign p_half  = mul_p + HALF_P;
    assign p_u     = mul_p + U_P;
    assign p_three = mul_p + THREE_P;

    assign ix_p2 = {1'b0, r_ix} + 2'd2;
    always_comb begin
        case (r_tap)
            2'd0:    tap_idx = (r_ix == '0) ? '0 : r_ix - 1'b1;
            2'd1:    tap_idx = r_ix;
            2'd2:    tap_idx = r_ix + 1'b1;
            default: tap_idx = (ix_p2 > {1'b0, n_last}) ? n_last : ix_p2[NW-1:0];
        endcase
    end

    // round half up, then saturate
    assign acc_t   = r_acc + HALF_A;
    assign acc_q   = acc_t >>> F;
    assign acc_ovf = !((&acc_q[AC-1:SB-1]) || (~|acc_q[AC-1:SB-1]));
    assign acc_sat = acc_ovf ? (acc_q[AC-1] ? {1'b1, {(SB-1){1'b0}}}
                                            : {1'b0, {(SB-1){1'b1}}})
                             : acc_q[SB-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (is_req) begin
                    if (bad_idx || !r_full || r_mode == MODE_ZERO) begin
                        n_state = ST_OUT;
                    end else if (is_last) begin
                        n_state = ST_RDA;
                    end else begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO: n_state = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                case (r_mode)
                    MODE_NEAREST: n_state = ST_RDA;
                    MODE_LINEAR:  n_state = ST_TRD;
                    default:      n_state = ST_WMUL;
                endcase
            end
            ST_WMUL: begin
                if (r_step == 4'd8) begin
                    n_state = ST_TRD;
                end
            end
            ST_TRD:  n_state = ST_TMUL;
            ST_TMUL: n_state = ST_TACC;
            ST_TACC: n_state = (r_tap == 2'd3) ? ST_FIN : ST_TRD;
            ST_FIN:  n_state = ST_OUT;
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        div_start  = (r_state == ST_DIV_GO);
        rd_en      = 1'b0;
        rd_addr    = r_addr;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            ST_RDA: begin
                rd_en = 1'b1;
            end
            ST_TRD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(tap_idx);
            end
            ST_TMUL: begin
                mul_a = r_w[r_tap];
                mul_b = MB'(rd_data);
            end
            ST_WMUL: begin
                case (r_step)
                    4'd0:    begin mul_a = d_s;  mul_b = MB'(e_s);    end
                    4'd1:    begin mul_a = d_s;  mul_b = MB'(h_s);    end
                    4'd2:    begin mul_a = h_s;  mul_b = MB'(e_s);    end
                    4'd3:    begin mul_a = r_de; mul_b = MB'(g_s);    end
                    4'd4:    begin mul_a = r_z;  mul_b = MB'(RECIP3); end
                    4'd5:    begin mul_a = r_he; mul_b = MB'(g_s);    end
                    4'd6:    begin mul_a = r_dh; mul_b = MB'(g_s);    end
                    4'd7:    begin mul_a = r_dh; mul_b = MB'(e_s);    end
                    default: begin mul_a = r_z;  mul_b = MB'(RECIP3); end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_count  <= IN_COUNT_RST;
            r_out_count <= OUT_COUNT_RST;
            r_mode      <= MODE_NEAREST;
            r_wptr      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_IN_COUNT: begin
                        r_in_count <= pwdata[IN_COUNT_W-1:0];
                        r_wptr     <= '0;
                        r_full     <= 1'b0;
                    end
                    REG_OUT_COUNT: r_out_count <= pwdata[OUT_COUNT_W-1:0];
                    REG_MODE:      r_mode      <= pwdata[MODE_W-1:0];
                    default: ;
                endcase
            end else if (is_load) begin
                if (wptr_inc >= n_eff) begin
                    r_wptr <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wptr <= wptr_inc;
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_data.value  <= r_res_value;
            r_out_data.status <= r_res_status;
        end
        case (r_state)
            ST_IDLE: begin
                r_num        <= NUM_W'(i_in_data.out_index) * NUM_W'(n_last);
                r_addr       <= AW'(n_last);
                r_res_value  <= '0;
                r_res_status <= bad_idx ? STAT_BAD_INDEX :
                                (!r_full ? STAT_NOT_FULL : STAT_OK);
            end
            ST_DIV: begin
                r_ix <= div_q[F+NW-1:F];
                r_d  <= div_q[F-1:0];
            end
            ST_PREP: begin
                r_addr <= AW'(r_ix + NW'(r_d[F-1]));
                r_step <= '0;
                r_tap  <= '0;
                r_acc  <= '0;
                r_w[0] <= '0;
                r_w[1] <= e_s;
                r_w[2] <= d_s;
                r_w[3] <= '0;
            end
            ST_WMUL: begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    4'd0:    r_de   <= p_half[F+MA-1:F];
                    4'd1:    r_dh   <= p_half[F+MA-1:F];
                    4'd2:    r_he   <= p_half[F+MA-1:F];
                    4'd3:    r_z    <= p_three[F+MA:F+1];
                    4'd4:    r_w[0] <= mul_p[F+MA-1:F];
                    4'd5:    r_w[1] <= p_u[F+MA:F+1];
                    4'd6:    r_w[2] <= p_u[F+MA:F+1];
                    4'd7:    r_z    <= p_three[F+MA:F+1];
                    default: r_w[3] <= -mul_p[F+MA-1:F];
                endcase
            end
            ST_TMUL: r_prod <= mul_p;
            ST_TACC: begin
                r_acc <= r_acc + AC'(r_prod);
                r_tap <= r_tap + 1'b1;
            end
            ST_FIN:  r_res_value <= acc_sat;
            ST_RDB:  r_res_value <= rd_data;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ri1d_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_num, {F{1'b0}}}),
        .i_divisor  (r_out_count - 1'b1),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    ri1d_store #(
        .DEPTH(MAX_SAMPLES),
        .AW   (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (is_load),
        .i_wr_addr (AW'(r_wptr)),
        .i_wr_data (i_in_data.sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

`ifndef SYNTHESIS
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr < n_eff)
        else $error("write pointer beyond set size");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result not presented");
`endif

endmodule
`default_nettype wire

### verif/resample_interpolator_1d_tb.sv
// Self-checking testbench for the 1-D resampling interpolator.
`timescale 1ns / 1ps
module resample_interpolator_1d_tb;
    import ri1d_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_data;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    resample_interpolator_1d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int DRAIN_CYCLES = 120;
    localparam int ITEM_TARGET  = 1250;

    // shadow copy of the block state
    logic signed [SAMPLE_BITS-1:0] shadow_store [1024];
    int unsigned                   shadow_wptr;
    bit                            shadow_full;
    logic [IN_COUNT_W-1:0]         cfg_in_count;
    logic [OUT_COUNT_W-1:0]        cfg_out_count;
    logic [MODE_W-1:0]             cfg_mode;

    t_out_item pending_results [$];
    bit        failed;
    bit        calm;
    int        items_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned active_count();
        if (cfg_in_count < 2) return 2;
        if (cfg_in_count > 1024) return 1024;
        return cfg_in_count;
    endfunction

    function automatic longint tap(int unsigned i);
        return longint'(shadow_store[i]);
    endfunction

    function automatic longint round_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint unsigned urnd(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint clip(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Works out one resampled point; updates the store on a load.
    function automatic bit resample_predict(input t_in_item it, output t_out_item res);
        int unsigned n;
        longint unsigned den, num, rem, d, e, h, g, de, dh, he;
        int unsigned ix, xm1, xp2;
        longint w0, w1, w2, w3, acc, val;
        n = active_count();
        val = 0;
        res.status = STAT_OK;
        if (it.command == CMD_LOAD) begin
            shadow_store[shadow_wptr] = it.sample;
            shadow_wptr++;
            if (shadow_wptr >= n) begin
                shadow_wptr = 0;
                shadow_full = 1'b1;
            end
            return 1'b0;
        end
        if (it.out_index >= cfg_out_count) begin
            res.status = STAT_BAD_INDEX;
        end else if (!shadow_full) begin
            res.status = STAT_NOT_FULL;
        end else if (cfg_mode == MODE_ZERO) begin
            val = 0;
        end else if (it.out_index == cfg_out_count - 1) begin
            val = tap(n - 1);
        end else begin
            den = cfg_out_count - 1;
            num = longint'(it.out_index) * (n - 1);
            ix  = num / den;
            rem = num % den;
            d   = (rem << 16) / den;
            if (cfg_mode == MODE_NEAREST) begin
                val = tap(ix + ((2 * rem >= den) ? 1 : 0));
            end else if (cfg_mode == MODE_LINEAR) begin
                acc = tap(ix) * longint'(65536 - d) + tap(ix + 1) * longint'(d);
                val = clip(round_q16(acc));
            end else begin
                e  = 65536 - d;
                h  = 65536 + d;
                g  = 131072 - d;
                de = urnd(d * e, 65536);
                dh = urnd(d * h, 65536);
                he = urnd(h * e, 65536);
                w0 = urnd(de * g, 6 * 65536);
                w1 = urnd(he * g, 2 * 65536);
                w2 = urnd(dh * g, 2 * 65536);
                w3 = -longint'(urnd(dh * e, 6 * 65536));
                xm1 = (ix == 0) ? 0 : ix - 1;
                xp2 = (ix + 2 > n - 1) ? n - 1 : ix + 2;
                acc = w0 * tap(xm1) + w1 * tap(ix) + w2 * tap(ix + 1) + w3 * tap(xp2);
                val = clip(round_q16(acc));
            end
        end
        res.value = val[SAMPLE_BITS-1:0];
        return 1'b1;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, o_out_data.value, o_out_data.status);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want.value, o_out_data.value);
                    failed = 1'b1;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_out_data.status);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
    end

    task automatic send_item(input t_in_item it);
        t_out_item res;
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (resample_predict(it, res)) pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic load(input logic signed [SAMPLE_BITS-1:0] s);
        t_in_item it;
        it.command   = CMD_LOAD;
        it.sample    = s;
        it.out_index = 16'($urandom);
        send_item(it);
    endtask

    task automatic request(input logic [OUT_COUNT_W-1:0] idx);
        t_in_item it;
        it.command   = CMD_REQUEST;
        it.sample    = 16'($urandom);
        it.out_index = idx;
        send_item(it);
    endtask

    // Waits until every expected result has come out, then pauses.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] reg_sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_sel)
            REG_IN_COUNT: begin
                cfg_in_count = data[IN_COUNT_W-1:0];
                shadow_wptr  = 0;
                shadow_full  = 1'b0;
            end
            REG_OUT_COUNT: cfg_out_count = data[OUT_COUNT_W-1:0];
            default:       cfg_mode = data[MODE_W-1:0];
        endcase
    endtask

    task automatic configure(input int ic, input int oc, input logic [MODE_W-1:0] m);
        settle();
        reg_write(REG_IN_COUNT, ic);
        reg_write(REG_OUT_COUNT, oc);
        reg_write(REG_MODE, m);
    endtask

    // Reset values, unfilled store, bad index and both errors together.
    task automatic test_errors();
        request(0);
        request(41);
        request(16'hFFFF);
        load(16'sh7FFF);
        load(-16'sh8000);
        load(16'sh7FFF);
        load(-16'sh8000);
        request(3);
        load(16'sh1234);
        request(0);
        request(20);
        request(40);
        request(41);
    endtask

    // Linear, cubic and zero modes on a small set with extreme samples, including the last point.
    task automatic test_modes();
        configure(4, 7, MODE_LINEAR);
        load(-16'sh8000);
        load(16'sh7FFF);
        load(-16'sh8000);
        load(16'sh7FFF);
        request(1);
        request(6);
        settle();
        reg_write(REG_MODE, MODE_CUBIC);
        request(1);
        request(3);
        settle();
        reg_write(REG_MODE, MODE_ZERO);
        request(2);
        request(6);
    endtask

    // Clamped in_count and the tiny out_count cases.
    task automatic test_edge_counts();
        configure(0, 1, MODE_NEAREST);
        load(16'sh0055);
        load(-16'sh0100);
        request(0);
        request(1);
        configure(1, 0, MODE_CUBIC);
        load(16'sh0001);
        load(16'sh7FFF);
        request(0);
        configure(3, 65535, MODE_CUBIC);
        load(16'sh7FFF);
        load(-16'sh8000);
        load(16'sh7FFF);
        request(16'd32767);
        request(16'd65534);
    endtask

    task automatic test_random();
        int  phase, n, reqs, ic, oc, pick;
        bit  big_done;
        phase    = 0;
        big_done = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(9);
            if (phase == 1 && !big_done) begin
                ic = 2047;
                big_done = 1'b1;
            end else if (pick == 1) begin
                ic = $urandom_range(1);
            end else begin
                ic = $urandom_range(20, 2);
            end
            case ($urandom_range(5))
                0: oc = 65535;
                1: oc = $urandom_range(2);
                2: oc = $urandom;
                default: oc = $urandom_range(200, 2);
            endcase
            configure(ic, oc, MODE_W'($urandom_range(3)));
            calm = (phase == 4);
            if ($urandom_range(9) == 0) request(16'($urandom));
            n = active_count();
            for (int k = 0; k < n; k++) load(16'($urandom));
            reqs = $urandom_range(40, 10);
            for (int k = 0; k < reqs; k++) begin
                if ($urandom_range(19) == 0) load(16'($urandom));
                else if ($urandom_range(9) == 0) request(16'($urandom));
                else if (oc == 0) request(0);
                else request(OUT_COUNT_W'($urandom_range(oc)));
            end
            calm = 1'b0;
            phase++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        failed       = 1'b0;
        calm         = 1'b0;
        items_sent   = 0;
        shadow_wptr  = 0;
        shadow_full  = 1'b0;
        cfg_in_count  = IN_COUNT_RST;
        cfg_out_count = OUT_COUNT_RST;
        cfg_mode      = MODE_NEAREST;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_errors();
        test_modes();
        test_edge_counts();
        test_random();
        settle();
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ri1d_pkg.sv
rtl/ri1d_store.sv
rtl/ri1d_div.sv
rtl/resample_interpolator_1d.sv
verif/resample_interpolator_1d_tb.sv
